/* hw/rtl/palc_pkg.sv */
// Package for the point list with cursor: field widths, operation codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package palc_pkg;

  localparam int MODE_W        = 3;
  localparam int COORD_W       = 16;
  localparam int ENTRY_COUNT_W = 7;
  localparam int POINT_W       = 2 * COORD_W;
  localparam int LIST_SIZE_DEF = 64;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIRST  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

  // Commands from the controller, at most one per cycle.
  typedef struct packed {
    logic latch;   // capture the input request
    logic exec;    // perform the captured operation
    logic ld_rd;   // load a result from the memory read data
    logic sh_rd;   // compaction: read the entry above the hole
    logic sh_wr;   // compaction: write it into the hole
  } palc_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic needs_read;   // captured operation succeeds and reads an entry
    logic is_del;       // captured operation is a delete
    logic sh_more;      // entries remain above the hole
    logic sh_more_nxt;  // entries remain after the current shift write
  } palc_stat_t;

endpackage

/* hw/rtl/point_array_list_with_cursor_top.sv */
// Top level of the point list with cursor: controller plus datapath.
// Depends on palc_pkg, palc_ctrl and palc_dp.
//
// Usage: one request on the in_ channel (in_mode, in_point_x, in_point_y)
// gives exactly one result on the out_ channel (out_ok, out_x, out_y,
// out_entry_count). A request is taken when in_valid is high and in_stall
// is low; a result is taken when out_valid is high and out_stall is low.
// Modes: clear, append, go to first, go to next, delete current.
//
// Steps, from the accepting edge to the result being loaded:
//   clear, append and any failing request: loaded when executed;
//   first, next: executed, then loaded from a registered read of the entry memory;
//   delete: as first and next, then each entry above the removed one is read
//   and written one slot down while the memory is compacted one entry at a time.
// A new request is taken only after the previous one completes, so
// the block handles one request at a time.
// A finished result waits in the output register while out_stall is high;
// the next request is still accepted, and its result is held back (no
// state change) until the output register frees up.
// Reset (rst_n low at a clock edge) empties the list, puts the cursor
// before the first entry and drops any pending result; the entry memory
// itself is not cleared and needs no sweep.
module point_array_list_with_cursor_top #(
  parameter int LIST_SIZE = palc_pkg::LIST_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [palc_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [palc_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [palc_pkg::COORD_W-1:0] in_point_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_ok,
  output logic signed [palc_pkg::COORD_W-1:0] out_x,
  output logic signed [palc_pkg::COORD_W-1:0] out_y,
  output logic [palc_pkg::ENTRY_COUNT_W-1:0]  out_entry_count
);

  palc_pkg::palc_cmd_t  cmd;
  palc_pkg::palc_stat_t stat;

  // Sequence each request through execute, read and compaction.
  palc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the list, count, cursor and the result register.
  palc_dp #(
    .LIST_SIZE (LIST_SIZE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_mode),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_entry_count (out_entry_count)
  );

  // The block turns busy right after taking a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted but block not busy");

  // A result only appears while a request is in progress.
  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result loaded with no request in progress");

  // Controller issues at most one command per cycle.
  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch, cmd.exec, cmd.ld_rd, cmd.sh_rd, cmd.sh_wr}))
    else $error("more than one datapath command");

endmodule

/* hw/rtl/palc_dp.sv */
// Datapath of the point list: entry memory, count, cursor, request and
// output registers. Depends on palc_pkg; driven by palc_ctrl commands.
module palc_dp #(
  parameter int LIST_SIZE = palc_pkg::LIST_SIZE_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  palc_pkg::palc_cmd_t                     cmd,
  output palc_pkg::palc_stat_t                    stat,
  input  logic [palc_pkg::MODE_W-1:0]             in_mode,
  input  logic signed [palc_pkg::COORD_W-1:0]     in_point_x,
  input  logic signed [palc_pkg::COORD_W-1:0]     in_point_y,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    out_ok,
  output logic signed [palc_pkg::COORD_W-1:0]     out_x,
  output logic signed [palc_pkg::COORD_W-1:0]     out_y,
  output logic [palc_pkg::ENTRY_COUNT_W-1:0]      out_entry_count
);

  localparam int AW = $clog2(LIST_SIZE);
  localparam int CW = $clog2(LIST_SIZE + 1);
  localparam logic [CW-1:0] FULL = CW'(LIST_SIZE);
  localparam logic [CW-1:0] ONE  = CW'(1);

  logic [palc_pkg::POINT_W-1:0] mem [LIST_SIZE];
  logic [palc_pkg::POINT_W-1:0] rdata_r;

  logic [palc_pkg::MODE_W-1:0]         op_mode_r;
  logic signed [palc_pkg::COORD_W-1:0] op_x_r, op_y_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cur_r, cur_nxt;     // cursor plus one; zero means before first
  logic [CW-1:0] sh_r, sh_nxt;       // index of the hole during compaction

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [palc_pkg::POINT_W-1:0] wr_data;
  logic          res_ok;

  logic out_valid_r, out_valid_nxt, out_ok_r, out_ok_nxt;
  logic signed [palc_pkg::COORD_W-1:0]  out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [palc_pkg::ENTRY_COUNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  logic can_append, can_first, can_next, can_del;

  assign can_append = (count_r < FULL);
  assign can_first  = (count_r != '0);
  assign can_next   = (cur_r < count_r);
  assign can_del    = (cur_r != '0);

  always_comb begin
    stat.out_free    = !out_valid_r || !out_stall;
    stat.is_del      = (op_mode_r == palc_pkg::MODE_DELETE);
    stat.sh_more     = (sh_r < count_r);
    stat.sh_more_nxt = ((sh_r + ONE) < count_r);
    case (op_mode_r)
      palc_pkg::MODE_FIRST:  stat.needs_read = can_first;
      palc_pkg::MODE_NEXT:   stat.needs_read = can_next;
      palc_pkg::MODE_DELETE: stat.needs_read = can_del;
      default:               stat.needs_read = 1'b0;
    endcase
  end

  // Operation decode and memory port selection.
  always_comb begin
    count_nxt = count_r;
    cur_nxt   = cur_r;
    sh_nxt    = sh_r;
    rd_en     = 1'b0;
    rd_addr   = sh_r[AW-1:0] + AW'(1);
    wr_en     = 1'b0;
    wr_addr   = sh_r[AW-1:0];
    wr_data   = rdata_r;
    res_ok    = 1'b0;
    if (cmd.exec) begin
      unique case (op_mode_r)
        palc_pkg::MODE_CLEAR: begin
          count_nxt = '0;
          cur_nxt   = '0;
          res_ok    = 1'b1;
        end
        palc_pkg::MODE_APPEND: begin
          if (can_append) begin
            wr_en     = 1'b1;
            wr_addr   = count_r[AW-1:0];
            wr_data   = {op_x_r, op_y_r};
            count_nxt = count_r + ONE;
            res_ok    = 1'b1;
          end
        end
        palc_pkg::MODE_FIRST: begin
          if (can_first) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            cur_nxt = ONE;
          end
        end
        palc_pkg::MODE_NEXT: begin
          if (can_next) begin
            rd_en   = 1'b1;
            rd_addr = cur_r[AW-1:0];
            cur_nxt = cur_r + ONE;
          end
        end
        palc_pkg::MODE_DELETE: begin
          if (can_del) begin
            rd_en     = 1'b1;
            rd_addr   = cur_r[AW-1:0] - AW'(1);
            sh_nxt    = cur_r - ONE;
            cur_nxt   = cur_r - ONE;
            count_nxt = count_r - ONE;
          end
        end
        default: ;
      endcase
    end else if (cmd.sh_rd) begin
      rd_en = 1'b1;
    end else if (cmd.sh_wr) begin
      wr_en  = 1'b1;
      sh_nxt = sh_r + ONE;
    end
  end

  // Output register: load on a result, drop when taken.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_cnt_nxt   = out_cnt_r;
    if (cmd.exec && !stat.needs_read) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = res_ok;
      out_x_nxt     = '0;
      out_y_nxt     = '0;
      out_cnt_nxt   = palc_pkg::ENTRY_COUNT_W'(count_nxt);
    end else if (cmd.ld_rd) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = 1'b1;
      out_x_nxt     = rdata_r[palc_pkg::POINT_W-1:palc_pkg::COORD_W];
      out_y_nxt     = rdata_r[palc_pkg::COORD_W-1:0];
      out_cnt_nxt   = palc_pkg::ENTRY_COUNT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_mode_r <= in_mode;
      op_x_r    <= in_point_x;
      op_y_r    <= in_point_y;
    end
    sh_r      <= sh_nxt;
    out_ok_r  <= out_ok_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_entry_count = out_cnt_r;

endmodule

/* hw/rtl/palc_ctrl.sv */
// Controller of the point list: sequences accept, execute, memory read
// and the delete compaction sweep. Depends on palc_pkg.
module palc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  palc_pkg::palc_stat_t stat,
  output palc_pkg::palc_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_RDATA = 3'd2;
  localparam logic [2:0] ST_SH_RD = 3'd3;
  localparam logic [2:0] ST_SH_WR = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = stat.needs_read ? ST_RDATA : ST_IDLE;
        end
      end
      ST_RDATA: begin
        if (stat.out_free) begin
          cmd.ld_rd = 1'b1;
          state_nxt = (stat.is_del && stat.sh_more) ? ST_SH_RD : ST_IDLE;
        end
      end
      ST_SH_RD: begin
        cmd.sh_rd = 1'b1;
        state_nxt = ST_SH_WR;
      end
      ST_SH_WR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = stat.sh_more_nxt ? ST_SH_RD : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

/* sim/palc_list_checker.sv */
// Checker for the point list with cursor: watches both channels, predicts
// each result from its own copy of the list and compares. Depends on palc_pkg.
`timescale 1ns / 1ps

module palc_list_checker #(
  parameter int LIST_SIZE = palc_pkg::LIST_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [palc_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [palc_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [palc_pkg::COORD_W-1:0] in_point_y,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_ok,
  input  logic signed [palc_pkg::COORD_W-1:0] out_x,
  input  logic signed [palc_pkg::COORD_W-1:0] out_y,
  input  logic [palc_pkg::ENTRY_COUNT_W-1:0]  out_entry_count,
  output int                                  fail_count,
  output int                                  pending_count
);
  import palc_pkg::*;

  typedef struct packed {
    logic                       ok;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic [ENTRY_COUNT_W-1:0]   count;
  } list_result_t;

  logic signed [COORD_W-1:0] shadow_x [LIST_SIZE];
  logic signed [COORD_W-1:0] shadow_y [LIST_SIZE];
  int                        shadow_count;
  int                        shadow_cursor;
  list_result_t              expected_results [$];
  int                        results_seen;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t MISMATCH: %s", $realtime, msg);
  endtask

  // Apply one list operation to the shadow copy and queue what it returns.
  task automatic predict_list_op(input logic [MODE_W-1:0] mode,
                                 input logic signed [COORD_W-1:0] px,
                                 input logic signed [COORD_W-1:0] py);
    list_result_t res;
    res = '0;
    case (mode)
      MODE_CLEAR: begin
        shadow_count  = 0;
        shadow_cursor = -1;
        res.ok        = 1'b1;
      end
      MODE_APPEND: begin
        if (shadow_count < LIST_SIZE) begin
          shadow_x[shadow_count] = px;
          shadow_y[shadow_count] = py;
          shadow_count++;
          res.ok = 1'b1;
        end
      end
      MODE_FIRST: begin
        if (shadow_count > 0) begin
          shadow_cursor = 0;
          res.x  = shadow_x[0];
          res.y  = shadow_y[0];
          res.ok = 1'b1;
        end
      end
      MODE_NEXT: begin
        if (shadow_cursor + 1 < shadow_count) begin
          shadow_cursor++;
          res.x  = shadow_x[shadow_cursor];
          res.y  = shadow_y[shadow_cursor];
          res.ok = 1'b1;
        end
      end
      MODE_DELETE: begin
        if (shadow_cursor >= 0 && shadow_cursor < shadow_count) begin
          res.x  = shadow_x[shadow_cursor];
          res.y  = shadow_y[shadow_cursor];
          res.ok = 1'b1;
          // close the hole so the list stays compact
          for (int i = shadow_cursor; i + 1 < shadow_count; i++) begin
            shadow_x[i] = shadow_x[i+1];
            shadow_y[i] = shadow_y[i+1];
          end
          shadow_count--;
          shadow_cursor--;
        end
      end
      default: ;
    endcase
    res.count = shadow_count[ENTRY_COUNT_W-1:0];
    expected_results.push_back(res);
  endtask

  task automatic check_result();
    list_result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                results_seen));
      return;
    end
    want = expected_results.pop_front();
    if (out_ok !== want.ok)
      report_mismatch($sformatf("result %0d ok %b, want %b", results_seen, out_ok, want.ok));
    if (out_x !== want.x)
      report_mismatch($sformatf("result %0d x %0d, want %0d", results_seen, out_x, want.x));
    if (out_y !== want.y)
      report_mismatch($sformatf("result %0d y %0d, want %0d", results_seen, out_y, want.y));
    if (out_entry_count !== want.count)
      report_mismatch($sformatf("result %0d count %0d, want %0d", results_seen,
                                out_entry_count, want.count));
  endtask

  initial begin
    fail_count    = 0;
    pending_count = 0;
    results_seen  = 0;
    shadow_count  = 0;
    shadow_cursor = -1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count  = 0;
      shadow_cursor = -1;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) predict_list_op(in_mode, in_point_x, in_point_y);
    end
    pending_count = expected_results.size();
  end

endmodule

/* sim/tb_top.sv */
// Testbench top for the point list with cursor: drives requests, stalls the
// result side and prints the verdict. Depends on palc_pkg, the block and palc_list_checker.
`timescale 1ns / 1ps

module tb_top;
  import palc_pkg::*;

  localparam int             LIST_SIZE    = LIST_SIZE_DEF;
  localparam int             ITEMS_TARGET = 1850;
  localparam int             LONG_HOLD    = 150;   // cycles of held-off results
  localparam int             DRAIN_CYCLES = 160;   // covers a full compaction pass
  localparam logic [MODE_W-1:0] MODE_MAX  = '1;    // top of the unused mode codes

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [MODE_W-1:0]          in_mode;
  logic signed [COORD_W-1:0]  in_point_x;
  logic signed [COORD_W-1:0]  in_point_y;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_ok;
  logic signed [COORD_W-1:0]  out_x;
  logic signed [COORD_W-1:0]  out_y;
  logic [ENTRY_COUNT_W-1:0]   out_entry_count;
  int                         fail_count;
  int                         pending_count;

  // Stimulus bookkeeping
  int items_sent;
  bit sender_quiet;   // no gaps between requests while set
  int hold_seq;       // bump to ask the receiver for one long hold-off

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_array_list_with_cursor_top #(
    .LIST_SIZE(LIST_SIZE)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_entry_count (out_entry_count)
  );

  palc_list_checker #(
    .LIST_SIZE(LIST_SIZE)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_entry_count (out_entry_count),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  // Offer one request at the current falling edge and hold it until the
  // block takes it. Returns after the following falling edge and any random gap;
  // with no gap in_valid stays high, so back-to-back requests keep valid up.
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py);
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_point_x <= px;
    in_point_y <= py;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
    idle_after_request();
  endtask

  // Insert a random gap: mostly none or short, now and then a long one.
  task automatic idle_after_request();
    int r;
    int gap;
    r   = $urandom_range(99);
    gap = 0;
    if (!sender_quiet) begin
      if (r >= 55 && r < 88) gap = $urandom_range(3, 1);
      else if (r >= 88)      gap = $urandom_range(30, 8);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop offering requests until every outstanding result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic send_random_point(input logic [MODE_W-1:0] mode);
    send_request(mode, COORD_W'($urandom_range(16'hFFFF)),
                 COORD_W'($urandom_range(16'hFFFF)));
  endtask

  // Optionally clear, then append a batch of random points.
  task automatic build_list(input bit do_clear, input int n);
    if (do_clear) send_random_point(MODE_CLEAR);
    repeat (n) send_random_point(MODE_APPEND);
  endtask

  // Iterate from the head, deleting some entries along the way; a few
  // steps run past the end so that the failing next and delete show up.
  task automatic walk_list(input int steps);
    if ($urandom_range(9) == 0) send_random_point(MODE_DELETE);   // before the cursor is moved to the head
    send_random_point(MODE_FIRST);
    repeat (steps) begin
      if ($urandom_range(99) < 62) send_random_point(MODE_NEXT);
      else                         send_random_point(MODE_DELETE);
    end
  endtask

  // Receiver: random stalls in bursts with quiet stretches, plus a long
  // hold-off whenever the stimulus asks for one.
  initial begin
    int served;
    int burst;
    int seg;
    int r;
    bit quiet;
    served    = 0;
    burst     = 0;
    seg       = 0;
    quiet     = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != served) begin
        served = hold_seq;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (seg == 0) begin
        quiet = ($urandom_range(3) == 0);
        seg   = $urandom_range(200, 40);
      end else begin
        seg--;
      end
      if (burst == 0 && !quiet) begin
        r = $urandom_range(99);
        if (r < 20)      burst = $urandom_range(3, 1);
        else if (r < 23) burst = $urandom_range(40, 8);
      end
      if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Give up if the run hangs.
  initial begin
    #15_000_000;
    $display("point_array_list_with_cursor_top test failed");
    $finish;
  end

  initial begin
    int pick;
    bit mid_hold_done;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = MODE_CLEAR;
    in_point_x   = '0;
    in_point_y   = '0;
    items_sent   = 0;
    sender_quiet = 1'b0;
    hold_seq     = 0;
    mid_hold_done = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reads and delete on the empty list must all fail.
    send_request(MODE_FIRST,  16'sh0000, 16'sh0000);
    send_request(MODE_NEXT,   16'sh0000, 16'sh0000);
    send_request(MODE_DELETE, 16'sh0000, 16'sh0000);
    send_request(MODE_CLEAR,  16'sh7FFF, -16'sh8000);
    // Extreme coordinates.
    send_request(MODE_APPEND, 16'sh7FFF, -16'sh8000);
    send_request(MODE_APPEND, -16'sh8000, 16'sh7FFF);
    send_request(MODE_APPEND, 16'sh0000, -16'sh0001);
    send_request(MODE_APPEND, -16'sh0001, 16'sh0000);
    // Delete before the cursor has moved onto an entry.
    send_request(MODE_DELETE, 16'sh0000, 16'sh0000);
    // Hold results off while requests keep coming, so the block backs up.
    hold_seq++;
    send_request(MODE_FIRST,  16'sh0000, 16'sh0000);
    send_request(MODE_NEXT,   16'sh0000, 16'sh0000);
    send_request(MODE_DELETE, 16'sh1234, 16'sh5678);   // removes entry 1, cursor steps back
    send_request(MODE_NEXT,   16'sh0000, 16'sh0000);   // reads the entry that slid down
    send_request(MODE_NEXT,   16'sh0000, 16'sh0000);
    send_request(MODE_NEXT,   16'sh0000, 16'sh0000);   // at the end: fails
    send_request(MODE_DELETE, 16'sh0000, 16'sh0000);   // removes the last entry
    send_request(MODE_DELETE, 16'sh0000, 16'sh0000);
    // Unused mode codes carry random payloads and must do nothing.
    for (int m = MODE_DELETE + 1; m <= MODE_MAX; m++) send_random_point(MODE_W'(m));
    send_request(MODE_FIRST,  16'sh0000, 16'sh0000);
    send_request(MODE_DELETE, 16'sh0000, 16'sh0000);
    send_request(MODE_DELETE, 16'sh0000, 16'sh0000);   // cursor already before first: fails
    wait_for_results();

    // Random: mostly well-formed build and walk sequences, some noise.
    while (items_sent < ITEMS_TARGET) begin
      sender_quiet = ($urandom_range(4) == 0);
      if (!mid_hold_done && items_sent > ITEMS_TARGET / 2) begin
        hold_seq++;
        mid_hold_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 33) begin
        if ($urandom_range(15) == 0) build_list(1'b1, LIST_SIZE + $urandom_range(3, 1));
        else                         build_list(1'($urandom_range(1)), $urandom_range(8, 1));
      end else if (pick < 78) begin
        walk_list($urandom_range(12, 1));
      end else if (pick < 90) begin
        repeat ($urandom_range(4, 1)) send_random_point(MODE_W'($urandom_range(MODE_MAX)));
      end else if (pick < 94) begin
        wait_for_results();
      end else begin
        build_list(1'b0, $urandom_range(4, 1));
      end
    end

    // Drain: wait for every result, then a full compaction's worth of cycles.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("point_array_list_with_cursor_top test passed");
    end else begin
      $display("point_array_list_with_cursor_top test failed");
    end
    $finish;
  end

endmodule
